FILE: rtl/lms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LED matrix scanner package
// Shared sizes, command and result codes, and the frame store request types.
// ----------------------------------------------------------------------------
package lms_pkg;

  localparam int COLUMNS    = 32;
  localparam int STORE_COLS = 64;
  localparam int COL_W      = $clog2(STORE_COLS);
  localparam int ADDR_W     = COL_W + 1;

  typedef enum logic [1:0] {
    CMD_SCAN  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_SHIFT  = 2'd0,
    KIND_SELECT = 2'd1,
    KIND_BLANK  = 2'd2
  } kind_t;

  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic              clr;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        red;
    logic [7:0]        green;
  } store_req_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
  } store_rd_t;

endpackage
`default_nettype wire

FILE: rtl/lms_cmd_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Command channel
// Valid/ready channel carrying scan, write and clear requests.
// ----------------------------------------------------------------------------
interface lms_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [4:0] column;
  logic       half;
  logic [7:0] red_byte;
  logic [7:0] green_byte;

  modport source (output valid, command, column, half, red_byte, green_byte, input ready);
  modport sink   (input valid, command, column, half, red_byte, green_byte, output ready);
endinterface
`default_nettype wire

FILE: rtl/lms_res_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying shift steps and row select / blank requests.
// ----------------------------------------------------------------------------
interface lms_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic       green_bit;
  logic       red_bit;
  logic [3:0] row_address;
  logic       row_disable;
  logic       frame_done;
  logic       last;

  modport source (output valid, kind, green_bit, red_bit, row_address, row_disable,
                  frame_done, last, input ready);
  modport sink   (input valid, kind, green_bit, red_bit, row_address, row_disable,
                  frame_done, last, output ready);
endinterface
`default_nettype wire

FILE: rtl/lms_frame_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Frame store
// Red and green column bytes, one word per column and half, with per-entry
// valid bits; an entry never written since reset or clear reads as all ones.
// ----------------------------------------------------------------------------
module lms_frame_store
  import lms_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire store_req_t req,
  output store_rd_t       rd
);

  localparam int DEPTH = 2 * STORE_COLS;

  logic [15:0]      mem [0:DEPTH-1];
  logic [DEPTH-1:0] vld;
  logic [15:0]      rd_word;
  logic             rd_hit;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= {req.red, req.green};
    end
    if (req.rd_en) begin
      rd_word <= mem[req.addr];
      rd_hit  <= vld[req.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || req.clr) begin
      vld <= '0;
    end else if (req.wr_en) begin
      vld[req.addr] <= 1'b1;
    end
  end

  assign rd.red   = rd_hit ? rd_word[15:8] : 8'hff;
  assign rd.green = rd_hit ? rd_word[7:0]  : 8'hff;

endmodule
`default_nettype wire

FILE: rtl/lms_scan_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scan sequencer
// Takes requests, steps the column counter over the store read port, selects
// the row bit and drives the registered result channel.
// ----------------------------------------------------------------------------
module lms_scan_ctrl
  import lms_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  lms_cmd_if.sink         cmd,
  lms_res_if.source       res,
  output store_req_t      store_req,
  input  wire store_rd_t  store_rd
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SHIFT = 3'b010,
    ST_BLANK = 3'b100
  } state_t;

  state_t           state;
  logic [COL_W-1:0] cnt;
  logic [3:0]       row;
  logic             d_valid;

  logic advance;
  logic issuing;
  logic accept;
  logic load_shift;
  logic load_sel;
  logic load_blank;
  cmd_t command;

  assign command    = cmd_t'(cmd.command);
  assign advance    = !res.valid || res.ready;
  assign issuing    = (state == ST_SHIFT) && (cnt < COL_W'(COLUMNS));
  assign cmd.ready  = (state == ST_IDLE);
  assign accept     = cmd.valid && cmd.ready;
  assign load_shift = advance && d_valid;
  assign load_sel   = (state == ST_SHIFT) && advance && !issuing && !d_valid;
  assign load_blank = (state == ST_BLANK) && advance;

  always_comb begin
    store_req.wr_en = accept && (command == CMD_WRITE)
                      && (COL_W'(cmd.column) < COL_W'(COLUMNS));
    store_req.clr   = accept && (command == CMD_CLEAR);
    store_req.rd_en = issuing && advance;
    store_req.red   = cmd.red_byte;
    store_req.green = cmd.green_byte;
    if (state == ST_IDLE) begin
      store_req.addr = {COL_W'(cmd.column), cmd.half};
    end else begin
      store_req.addr = {cnt, row[3]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      row       <= '0;
      d_valid   <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      if (advance) begin
        d_valid <= issuing;
      end
      if (load_shift || load_sel || load_blank) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (command)
              CMD_SCAN: begin
                state <= ST_SHIFT;
                cnt   <= '0;
              end
              CMD_CLEAR: state <= ST_BLANK;
              default:   state <= ST_IDLE;
            endcase
          end
        end
        ST_SHIFT: begin
          if (advance) begin
            if (issuing) begin
              cnt <= cnt + 1'b1;
            end else if (!d_valid) begin
              state <= ST_IDLE;
              row   <= row + 1'b1;
            end
          end
        end
        ST_BLANK: begin
          if (advance) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load_shift) begin
      res.kind        <= KIND_SHIFT;
      res.green_bit   <= store_rd.green[~row[2:0]];
      res.red_bit     <= store_rd.red[~row[2:0]];
      res.row_address <= '0;
      res.row_disable <= 1'b0;
      res.frame_done  <= 1'b0;
      res.last        <= 1'b0;
    end else if (load_sel) begin
      res.kind        <= KIND_SELECT;
      res.green_bit   <= 1'b0;
      res.red_bit     <= 1'b0;
      res.row_address <= row;
      res.row_disable <= 1'b0;
      res.frame_done  <= (row == 4'hf);
      res.last        <= 1'b1;
    end else if (load_blank) begin
      res.kind        <= KIND_BLANK;
      res.green_bit   <= 1'b0;
      res.red_bit     <= 1'b0;
      res.row_address <= '0;
      res.row_disable <= 1'b1;
      res.frame_done  <= 1'b0;
      res.last        <= 1'b1;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/led_matrix_row_scanner.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LED matrix row scanner
// Two-color, 16-row scanner with red and green frame stores.
//
// cmd carries requests: scan one row, write one column's red and green bytes
// for one half, or clear both stores to ones and blank the rows. res carries
// results: one shift step per column, then a row select marked last for a
// scan; a single blank marked last for a clear; nothing for a write.
// A write leaves the block in its idle state, so it stays ready.
// A scan steps the column counter one column a cycle, unless res stalls, over
// the single store read port; its registered read data then passes through the
// result register. cmd.ready is low while a scan or clear is in progress.
// When a result is waiting and res.ready is low, the column counter and store
// read hold, so no step is lost.
// Reset empties the result register, selects row zero and makes both stores
// read as all ones; no clearing pass is needed.
// ----------------------------------------------------------------------------
module led_matrix_row_scanner
  import lms_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  lms_cmd_if.sink   cmd,
  lms_res_if.source res
);

  store_req_t store_req;
  store_rd_t  store_rd;

  lms_scan_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .res       (res),
    .store_req (store_req),
    .store_rd  (store_rd)
  );

  lms_frame_store u_store (
    .clk (clk),
    .rst (rst),
    .req (store_req),
    .rd  (store_rd)
  );

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    !(store_req.wr_en && store_req.rd_en))
    else $error("store write and read in the same cycle");

  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    store_req.rd_en |-> !cmd.ready)
    else $error("store read while accepting requests");

  a_clear_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready && (cmd.command == CMD_CLEAR)) |=> !cmd.ready)
    else $error("clear request did not hold off the next request");

  a_reset_empty: assert property (@(posedge clk) rst |=> !res.valid)
    else $error("result valid after reset");

endmodule
`default_nettype wire
